>>> rtl/lfrsm_pkg.sv
// ----------------------------------------------------------------------------
// lfrsm_pkg
// Shared types and constants of the link frame receiver and status monitor.
// ----------------------------------------------------------------------------
package lfrsm_pkg;

    // heartbeat age counter width
    localparam int AGE_BITS = 16;
    // reported age width
    localparam int RPT_BITS = 16;

    // configuration register indexes
    localparam logic [2:0] REG_START_BYTE     = 3'd0;
    localparam logic [2:0] REG_MAX_PAYLOAD    = 3'd1;
    localparam logic [2:0] REG_STATUS_TYPE    = 3'd2;
    localparam logic [2:0] REG_HEARTBEAT_TYPE = 3'd3;
    localparam logic [2:0] REG_HB_TIMEOUT     = 3'd4;

    // configuration reset values
    localparam logic [7:0]  START_BYTE_RST     = 8'hAB;
    localparam logic [7:0]  MAX_PAYLOAD_RST    = 8'd220;
    localparam logic [7:0]  STATUS_TYPE_RST    = 8'h01;
    localparam logic [7:0]  HEARTBEAT_TYPE_RST = 8'h02;
    localparam logic [15:0] HB_TIMEOUT_RST     = 16'd3000;

    // drop reasons
    localparam logic [1:0] DROP_NONE  = 2'd0;
    localparam logic [1:0] DROP_LEN   = 2'd1;
    localparam logic [1:0] DROP_CHECK = 2'd2;

    // live configuration
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  max_payload_len;
        logic [7:0]  status_type_code;
        logic [7:0]  heartbeat_type_code;
        logic [15:0] heartbeat_timeout;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic                usb_mounted;
        logic                usb_suspended;
        logic                link_up;
        logic [RPT_BITS-1:0] heartbeat_age;
        logic                frame_accepted;
        logic [7:0]          accepted_type;
        logic [7:0]          accepted_len;
        logic [1:0]          drop_code;
    } res_t;

endpackage

>>> rtl/lfrsm_stream_if.sv
// ----------------------------------------------------------------------------
// lfrsm_in_if / lfrsm_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lfrsm_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lfrsm_out_if;
    logic        valid;
    logic        ready;
    logic        usb_mounted;
    logic        usb_suspended;
    logic        link_up;
    logic [15:0] heartbeat_age;
    logic        frame_accepted;
    logic [7:0]  accepted_type;
    logic [7:0]  accepted_len;
    logic [1:0]  drop_code;

    modport source (output valid, output usb_mounted, output usb_suspended,
                    output link_up, output heartbeat_age, output frame_accepted,
                    output accepted_type, output accepted_len, output drop_code,
                    input ready);
    modport sink (input valid, input usb_mounted, input usb_suspended,
                  input link_up, input heartbeat_age, input frame_accepted,
                  input accepted_type, input accepted_len, input drop_code,
                  output ready);
endinterface

>>> rtl/lfrsm_deframer.sv
// ----------------------------------------------------------------------------
// lfrsm_deframer
// Frame parser, status flags and heartbeat age; one item per step.
// ----------------------------------------------------------------------------
module lfrsm_deframer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              is_tick,
    input  logic [7:0]        rx_byte,
    input  lfrsm_pkg::cfg_t   cfg,
    output lfrsm_pkg::res_t   res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    localparam logic [lfrsm_pkg::AGE_BITS-1:0] AGE_MAX = '1;
    localparam int EXT_BITS = 33;

    logic [2:0]                      phase_reg, phase_next;
    logic [7:0]                      type_reg, type_next;
    logic [7:0]                      len_reg, len_next;
    logic [7:0]                      check_reg, check_next;
    logic [7:0]                      count_reg, count_next;
    logic [7:0]                      first_reg, first_next;
    logic                            mounted_reg, mounted_next;
    logic                            suspended_reg, suspended_next;
    logic                            seen_reg, seen_next;
    logic [lfrsm_pkg::AGE_BITS-1:0]  age_reg, age_next;
    logic [7:0]                      count_inc;
    logic                            accepted;
    logic [1:0]                      drop;
    logic                            saturated;
    logic [EXT_BITS-1:0]             age_ext;

    assign count_inc = count_reg + 8'd1;

    // parser and monitor next state
    always_comb
    begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        check_next     = check_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        mounted_next   = mounted_reg;
        suspended_next = suspended_reg;
        seen_next      = seen_reg;
        age_next       = age_reg;
        accepted       = 1'b0;
        drop           = lfrsm_pkg::DROP_NONE;
        if (is_tick)
        begin
            if (seen_reg && (age_reg != AGE_MAX))
            begin
                age_next = age_reg + 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    check_next = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = rx_byte;
                    check_next = check_reg ^ rx_byte;
                    count_next = 8'd0;
                    if (rx_byte > cfg.max_payload_len)
                    begin
                        phase_next = PH_IDLE;
                        drop       = lfrsm_pkg::DROP_LEN;
                    end
                    else if (rx_byte == 8'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (count_reg == 8'd0)
                    begin
                        first_next = rx_byte;
                    end
                    count_next = count_inc;
                    check_next = check_reg ^ rx_byte;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (rx_byte == check_reg)
                    begin
                        accepted = 1'b1;
                        if (type_reg == cfg.status_type_code)
                        begin
                            if (len_reg != 8'd0)
                            begin
                                mounted_next   = first_reg[0];
                                suspended_next = first_reg[1];
                            end
                        end
                        else if (type_reg == cfg.heartbeat_type_code)
                        begin
                            age_next  = '0;
                            seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        drop = lfrsm_pkg::DROP_CHECK;
                    end
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = (rx_byte == cfg.start_byte) ? PH_TYPE : PH_IDLE;
                end
            endcase
        end
    end

    // result from the state after this item
    assign saturated = (age_next == AGE_MAX);
    assign age_ext   = EXT_BITS'(age_next);

    always_comb
    begin
        res.usb_mounted    = mounted_next;
        res.usb_suspended  = suspended_next;
        res.link_up        = seen_next && !saturated &&
                             (age_ext < EXT_BITS'(cfg.heartbeat_timeout));
        if (!seen_next || saturated ||
            (age_ext > EXT_BITS'({lfrsm_pkg::RPT_BITS{1'b1}})))
        begin
            res.heartbeat_age = '1;
        end
        else
        begin
            res.heartbeat_age = age_ext[lfrsm_pkg::RPT_BITS-1:0];
        end
        res.frame_accepted = accepted;
        res.accepted_type  = accepted ? type_reg : 8'd0;
        res.accepted_len   = accepted ? len_reg : 8'd0;
        res.drop_code      = drop;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            type_reg      <= 8'd0;
            len_reg       <= 8'd0;
            check_reg     <= 8'd0;
            count_reg     <= 8'd0;
            first_reg     <= 8'd0;
            mounted_reg   <= 1'b0;
            suspended_reg <= 1'b0;
            seen_reg      <= 1'b0;
            age_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            check_reg     <= check_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            mounted_reg   <= mounted_next;
            suspended_reg <= suspended_next;
            seen_reg      <= seen_next;
            age_reg       <= age_next;
        end
    end

    // ticks never complete or drop a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_tick) |-> (!res.frame_accepted && res.drop_code == lfrsm_pkg::DROP_NONE))
        else $error("tick produced a frame event");

    // age only moves on a tick or a heartbeat frame
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(age_reg))
        else $error("age changed without an item");

    // payload phase never runs past the announced length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < len_reg))
        else $error("payload count past length");

endmodule

>>> rtl/link_frame_receiver_status_monitor_core.sv
// ----------------------------------------------------------------------------
// link_frame_receiver_status_monitor_core
// Link byte deframer with XOR check, status flags and heartbeat watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one item per transfer: a received link byte
//   (req_type 0) or a one millisecond tick (req_type 1).
//   out_chan carries exactly one result per input item, in order, showing
//   the flags, link state and heartbeat age after that item plus any frame
//   completion or drop for that byte.
//   Configuration is written through cfg_we / cfg_addr / cfg_wdata while
//   the block is idle; indexes beyond the register list are ignored.
// Timing:
//   a result is registered into the buffer on its input transfer; throughput
//   is one item per cycle while in_chan.ready is high, set by the parser step.
//   A two-entry result buffer sits on the output, so an input transfer is
//   still taken while one result waits; in_chan.ready drops only when both
//   entries are full and the receiver stalls.
// Reset:
//   rst_n clears the parser to idle, the flags and the heartbeat state,
//   empties the result buffer and loads the default configuration.
// ----------------------------------------------------------------------------
module link_frame_receiver_status_monitor_core
(
    input  logic        clk,
    input  logic        rst_n,
    lfrsm_in_if.sink    in_chan,
    lfrsm_out_if.source out_chan,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    lfrsm_pkg::cfg_t cfg_reg;
    lfrsm_pkg::res_t step_res;
    lfrsm_pkg::res_t head_reg, head_next;
    lfrsm_pkg::res_t tail_reg, tail_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte          <= lfrsm_pkg::START_BYTE_RST;
            cfg_reg.max_payload_len     <= lfrsm_pkg::MAX_PAYLOAD_RST;
            cfg_reg.status_type_code    <= lfrsm_pkg::STATUS_TYPE_RST;
            cfg_reg.heartbeat_type_code <= lfrsm_pkg::HEARTBEAT_TYPE_RST;
            cfg_reg.heartbeat_timeout   <= lfrsm_pkg::HB_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lfrsm_pkg::REG_START_BYTE:     cfg_reg.start_byte <= cfg_wdata[7:0];
                lfrsm_pkg::REG_MAX_PAYLOAD:    cfg_reg.max_payload_len <= cfg_wdata[7:0];
                lfrsm_pkg::REG_STATUS_TYPE:    cfg_reg.status_type_code <= cfg_wdata[7:0];
                lfrsm_pkg::REG_HEARTBEAT_TYPE: cfg_reg.heartbeat_type_code <= cfg_wdata[7:0];
                lfrsm_pkg::REG_HB_TIMEOUT:     cfg_reg.heartbeat_timeout <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // handshake
    assign in_chan.ready = (count_reg != 2'd2);
    assign push          = in_chan.valid && in_chan.ready;
    assign pop           = out_chan.valid && out_chan.ready;

    // per-item step
    lfrsm_deframer u_deframer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (push),
        .is_tick (in_chan.req_type),
        .rx_byte (in_chan.rx_byte),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    // two-entry result buffer
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = step_res;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (pop && push)
                begin
                    head_next = step_res;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
                else if (push)
                begin
                    tail_next  = step_res;
                    count_next = 2'd2;
                end
            end
            default:
            begin
                if (pop)
                begin
                    head_next  = tail_reg;
                    count_next = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    // output channel
    assign out_chan.valid          = (count_reg != 2'd0);
    assign out_chan.usb_mounted    = head_reg.usb_mounted;
    assign out_chan.usb_suspended  = head_reg.usb_suspended;
    assign out_chan.link_up        = head_reg.link_up;
    assign out_chan.heartbeat_age  = head_reg.heartbeat_age;
    assign out_chan.frame_accepted = head_reg.frame_accepted;
    assign out_chan.accepted_type  = head_reg.accepted_type;
    assign out_chan.accepted_len   = head_reg.accepted_len;
    assign out_chan.drop_code      = head_reg.drop_code;

    // buffer never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    // a transfer out without a transfer in drains one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("result buffer lost or repeated an entry");

    // link up implies a reportable age
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.link_up) |-> (out_chan.heartbeat_age != 16'hFFFF))
        else $error("link up with saturated age");

endmodule
